>>> rtl/rss_pkg.sv
`timescale 1ns / 1ps

package rss_pkg;

  // Width of every address field on the ports.
  localparam int unsigned FIELD_W = 32;
  // Entries in the command queue and in the result queue.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FILTER = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_REWIND = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP
  } back_state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [FIELD_W-1:0] range_low;
    logic [FIELD_W-1:0] range_high;
  } rss_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] piece_low;
    logic [FIELD_W-1:0] piece_high;
    logic               piece_valid;
    logic               last_piece;
    logic               table_overflow;
  } rss_result_t;

  // Decoded command handed from the front end to the back end.
  typedef struct packed {
    op_e                op;
    logic               keep_empty;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
  } rss_cmd_t;

  typedef struct packed {
    logic busy;
    logic table_full;
    logic overflow;
  } rss_status_t;

endpackage

>>> rtl/rss_ram.sv
`timescale 1ns / 1ps

module rss_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rss_front.sv
`timescale 1ns / 1ps

module rss_front import rss_pkg::*; #(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  rss_item_t item_i,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i,
  output rss_cmd_t  cmd_o
);

  localparam int unsigned AW    = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [AW-1:0]    lo_m;
  logic [AW-1:0]    hi_m;
  rss_cmd_t         cmd_in;
  rss_cmd_t         queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             wr_en;
  logic             rd_en;

  // Addresses are cut to the configured address width, and a keep range
  // whose high end lies below its low end is flagged here once.
  always_comb begin
    lo_m              = item_i.range_low[AW-1:0];
    hi_m              = item_i.range_high[AW-1:0];
    cmd_in.op         = op_e'(item_i.action);
    cmd_in.keep_empty = (lo_m > hi_m);
    cmd_in.lo         = FIELD_W'(lo_m);
    cmd_in.hi         = FIELD_W'(hi_m);
  end

  assign full_o      = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

endmodule

>>> rtl/rss_back.sv
`timescale 1ns / 1ps

module rss_back import rss_pkg::*; #(
  parameter int unsigned EXCL_DEPTH = 32,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  rss_cmd_t    cmd_i,
  input  logic        pop_i,
  output logic        empty_o,
  output rss_result_t result_o,
  output rss_status_t status_o
);

  localparam int unsigned AW    = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int unsigned IW    = (EXCL_DEPTH > 1) ? $clog2(EXCL_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(EXCL_DEPTH + 1);
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  back_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] lo1_q, lo1_d;
  logic [AW-1:0] hi1_q, hi1_d;
  logic          alive_q, alive_d;
  logic          pend_valid_q, pend_valid_d;
  logic [AW-1:0] pend_lo_q, pend_lo_d;
  logic [AW-1:0] pend_hi_q, pend_hi_d;

  logic            ram_we;
  logic            ram_re;
  logic [2*AW-1:0] ram_wdata;
  logic [2*AW-1:0] ram_rdata;
  logic [AW-1:0]   lo2;
  logic [AW-1:0]   hi2;

  logic          cmp_skip;
  logic          cmp_above;
  logic          cmp_head;
  logic          cmp_eq;
  logic          cmp_less;
  logic          cmp_new;
  logic [AW-1:0] head_hi;
  logic [AW-1:0] tail_lo;
  logic          scan_more;
  logic          stall;

  rss_result_t      oq_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] oq_wr_q;
  logic [PTR_W-1:0] oq_rd_q;
  logic [CNT_W-1:0] oq_cnt_q;
  logic             out_full;
  logic             out_push;
  logic             out_pop;
  rss_result_t      out_data;

  rss_ram #(
    .WIDTH (2 * AW),
    .DEPTH (EXCL_DEPTH)
  ) u_excl_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign lo2       = ram_rdata[2*AW-1:AW];
  assign hi2       = ram_rdata[AW-1:0];
  assign ram_wdata = {cmd_i.lo[AW-1:0], cmd_i.hi[AW-1:0]};

  assign out_full = (oq_cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o  = (oq_cnt_q == '0);
  assign out_pop  = pop_i && !empty_o;
  assign result_o = oq_q[oq_rd_q];

  assign cmd_ready_o         = (state_q == ST_IDLE);
  assign status_o.busy       = (state_q != ST_IDLE);
  assign status_o.table_full = (count_q == CW'(EXCL_DEPTH));
  assign status_o.overflow   = ovf_q;

  // Compare the remaining keep range against the table entry just read.
  always_comb begin
    cmp_skip  = (lo1_q > hi2);
    cmp_above = (lo2 > hi1_q);
    cmp_head  = (lo1_q < lo2);
    cmp_eq    = (hi1_q == hi2);
    cmp_less  = (hi1_q < hi2);
    head_hi   = lo2 - AW'(1);
    tail_lo   = hi2 + AW'(1);
    cmp_new   = !cmp_skip && (cmp_above || cmp_head);
    scan_more = (scan_q < count_q);
    case (state_q)
      ST_SCAN: stall = out_full && (alive_q ? (!scan_more && pend_valid_q) : 1'b1);
      ST_CMP:  stall = out_full && cmp_new && pend_valid_q;
      default: stall = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == OP_FILTER)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (alive_q && scan_more) begin
            state_d = ST_CMP;
          end else if (!alive_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CMP: begin
        if (!stall) begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // A found piece is held back one step, because only the next step tells
  // whether it is the last one of its keep range.
  always_comb begin
    count_d      = count_q;
    scan_d       = scan_q;
    ovf_d        = ovf_q;
    lo1_d        = lo1_q;
    hi1_d        = hi1_q;
    alive_d      = alive_q;
    pend_valid_d = pend_valid_q;
    pend_lo_d    = pend_lo_q;
    pend_hi_d    = pend_hi_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    out_push     = 1'b0;
    out_data.piece_low      = FIELD_W'(pend_lo_q);
    out_data.piece_high     = FIELD_W'(pend_hi_q);
    out_data.piece_valid    = 1'b1;
    out_data.last_piece     = 1'b0;
    out_data.table_overflow = ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_APPEND: begin
              if (count_q < CW'(EXCL_DEPTH)) begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_FILTER: begin
              lo1_d        = cmd_i.lo[AW-1:0];
              hi1_d        = cmd_i.hi[AW-1:0];
              alive_d      = !cmd_i.keep_empty;
              pend_valid_d = 1'b0;
            end
            OP_CLEAR: begin
              count_d = '0;
              scan_d  = '0;
              ovf_d   = 1'b0;
            end
            OP_REWIND: begin
              scan_d = '0;
            end
            default: begin
              scan_d = scan_q;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (alive_q && scan_more) begin
            ram_re = 1'b1;
          end else if (alive_q) begin
            out_push     = pend_valid_q;
            pend_lo_d    = lo1_q;
            pend_hi_d    = hi1_q;
            pend_valid_d = 1'b1;
            alive_d      = 1'b0;
          end else begin
            out_push            = 1'b1;
            out_data.last_piece = 1'b1;
            if (!pend_valid_q) begin
              out_data.piece_low   = '0;
              out_data.piece_high  = '0;
              out_data.piece_valid = 1'b0;
            end
          end
        end
      end
      ST_CMP: begin
        if (!stall) begin
          if (cmp_new) begin
            out_push     = pend_valid_q;
            pend_lo_d    = lo1_q;
            pend_hi_d    = cmp_above ? hi1_q : head_hi;
            pend_valid_d = 1'b1;
          end
          if (cmp_skip) begin
            scan_d = scan_q + CW'(1);
          end else if (cmp_above) begin
            alive_d = 1'b0;
          end else begin
            lo1_d = lo2;
            if (cmp_eq) begin
              scan_d  = scan_q + CW'(1);
              alive_d = 1'b0;
            end else if (cmp_less) begin
              alive_d = 1'b0;
            end else begin
              lo1_d  = tail_lo;
              scan_d = scan_q + CW'(1);
            end
          end
        end
      end
      default: begin
        alive_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      scan_q       <= '0;
      ovf_q        <= 1'b0;
      alive_q      <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      ovf_q        <= ovf_d;
      alive_q      <= alive_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo1_q     <= lo1_d;
    hi1_q     <= hi1_d;
    pend_lo_q <= pend_lo_d;
    pend_hi_q <= pend_hi_d;
    if (out_push) begin
      oq_q[oq_wr_q] <= out_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (out_push) begin
        oq_wr_q <= (oq_wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : oq_wr_q + PTR_W'(1);
      end
      if (out_pop) begin
        oq_rd_q <= (oq_rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : oq_rd_q + PTR_W'(1);
      end
      oq_cnt_q <= oq_cnt_q + CNT_W'(out_push) - CNT_W'(out_pop);
    end
  end

endmodule

>>> rtl/range_set_subtract_unit.sv
`timescale 1ns / 1ps

// Range set subtraction. Exclusion ranges are appended to an internal table
// in ascending, non-overlapping order; keep ranges, also ascending, are then
// filtered against it, and the parts of each keep range that no exclusion
// range covers come out as result transactions, the final one marked
// last_piece. A keep range with nothing left gives one result with
// piece_valid low. Other actions clear the table or rewind the scan pointer.
// Input: a transaction is taken when push is high and full is low. Output:
// the oldest result sits on result_o while empty is low and is taken when pop
// is high. A two-entry command queue separates the decoder from the engine,
// and a two-entry result queue lets results wait without blocking new input.
// Timing: an append, clear or rewind is handled while the engine is idle, so
// they flow at one per cycle as long as no filter is in progress. A filter
// walks the table from the scan pointer; each entry it examines takes a
// registered RAM read, then a compare. The pointer only moves forward, apart
// from a clear or rewind, so a walk stays short on average. Reset empties
// both queues, the table count, the pointer and the overflow flag. When pop
// stays low the engine stops once the result queue is full.
module range_set_subtract_unit import rss_pkg::*; #(
  parameter int unsigned EXCL_DEPTH = 32,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  rss_item_t   item_i,
  output logic        empty,
  input  logic        pop,
  output rss_result_t result_o
);

  logic        cmd_valid;
  logic        cmd_ready;
  rss_cmd_t    cmd;
  rss_status_t status;

  // The front end decodes each input transaction and queues it.
  rss_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // The back end owns the table and walks it for each keep range.
  rss_back #(
    .EXCL_DEPTH (EXCL_DEPTH),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  // An empty result always closes its keep range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.piece_valid) |-> result_o.last_piece)
    else $error("empty result not marked last");

  // A filter command taken by the engine keeps it busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready && (cmd.op == OP_FILTER)) |=> status.busy)
    else $error("filter command did not start a scan");

  // The table only stops being full through a clear command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(status.table_full) |-> $past(cmd_valid && cmd_ready && (cmd.op == OP_CLEAR)))
    else $error("table count dropped without a clear");

  // A dropped append can only have happened against a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.overflow |-> status.table_full)
    else $error("overflow flag set while table not full");
`endif

endmodule

>>> bench/range_set_subtract_unit_tb.sv
`timescale 1ns / 1ps

module range_set_subtract_unit_tb;
  import rss_pkg::*;

  localparam int unsigned EXCL_DEPTH = 32;
  localparam int unsigned ADDR_BITS = 32;
  // Generous bound: even a filter that walks the whole table against a
  // receiver that stalls most of the time finishes far inside this.
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Quiet period after the last expected piece, to catch stray results.
  localparam int unsigned DRAIN_CYCLES = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  rss_item_t   item_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  rss_result_t result_o;

  range_set_subtract_unit #(
    .EXCL_DEPTH(EXCL_DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  always #10 clk_i = ~clk_i;

  // Commands waiting to be offered to the block, and the pieces the block
  // owes us, oldest first.
  rss_item_t   cmd_backlog[$];
  rss_result_t expected_pieces[$];

  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Idle rates in percent for each side; the stimulus sequencer changes them
  // between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Shadow copy of the exclusion table, the scan pointer and the sticky
  // overflow flag, kept in step with every accepted transaction.
  logic [31:0] bar_lo[EXCL_DEPTH];
  logic [31:0] bar_hi[EXCL_DEPTH];
  int unsigned bar_count = 0;
  int unsigned scan_ptr = 0;
  logic        drop_flag = 1'b0;

  function automatic void owe_piece(logic [31:0] lo, logic [31:0] hi, logic valid);
    rss_result_t r;
    r.piece_low      = lo;
    r.piece_high     = hi;
    r.piece_valid    = valid;
    r.last_piece     = 1'b0;
    r.table_overflow = drop_flag;
    expected_pieces.push_back(r);
  endfunction

  // Applies one accepted command to the shadow state. A filter walks the
  // table from the scan pointer forward and records every surviving piece
  // of the keep range; the pointer never moves back except on rewind/clear.
  function automatic void subtract_keep_range(rss_item_t it);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] ex_lo;
    logic [31:0] ex_hi;
    bit          alive;
    int unsigned n;
    lo = it.range_low;
    hi = it.range_high;
    case (op_e'(it.action))
      OP_APPEND: begin
        if (bar_count < EXCL_DEPTH) begin
          bar_lo[bar_count] = lo;
          bar_hi[bar_count] = hi;
          bar_count++;
        end else begin
          drop_flag = 1'b1;
        end
      end
      OP_FILTER: begin
        n = 0;
        // An inverted keep range has nothing in it and leaves the pointer.
        alive = (lo <= hi);
        while (alive && scan_ptr < bar_count) begin
          ex_lo = bar_lo[scan_ptr];
          ex_hi = bar_hi[scan_ptr];
          if (lo > ex_hi) begin
            // Exclusion lies wholly below what is left; skip it for good.
            scan_ptr++;
          end else if (ex_lo > hi) begin
            // Exclusion lies wholly above; the rest survives untouched.
            owe_piece(lo, hi, 1'b1);
            n++;
            alive = 0;
          end else begin
            if (lo < ex_lo) begin
              owe_piece(lo, ex_lo - 32'd1, 1'b1);
              n++;
              lo = ex_lo;
            end
            if (hi == ex_hi) begin
              scan_ptr++;
              alive = 0;
            end else if (hi < ex_hi) begin
              // The exclusion reaches past this keep range and may still
              // cover the next one, so the pointer stays.
              alive = 0;
            end else begin
              lo = ex_hi + 32'd1;
              scan_ptr++;
            end
          end
        end
        if (alive) begin
          owe_piece(lo, hi, 1'b1);
          n++;
        end
        if (n == 0) owe_piece('0, '0, 1'b0);
        expected_pieces[expected_pieces.size() - 1].last_piece = 1'b1;
      end
      OP_CLEAR: begin
        bar_count = 0;
        scan_ptr  = 0;
        drop_flag = 1'b0;
      end
      default: begin
        scan_ptr = 0;
      end
    endcase
  endfunction

  // Driver: offers the backlog one transaction at a time. A transaction that
  // is held off by full stays on the bus unchanged until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        subtract_keep_range(item_i);
        accepted_count++;
      end
      if (!push || !full) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          item_i <= cmd_backlog.pop_front();
          push   <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes result transactions at a random rate and checks each one
  // against the oldest owed piece.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pieces.size() == 0) begin
          $display("%0t: expected no piece, got %h..%h v%b l%b o%b",
                   $time, result_o.piece_low, result_o.piece_high, result_o.piece_valid,
                   result_o.last_piece, result_o.table_overflow);
          mismatches++;
        end else begin
          if (result_o.piece_low !== expected_pieces[0].piece_low ||
              result_o.piece_high !== expected_pieces[0].piece_high ||
              result_o.piece_valid !== expected_pieces[0].piece_valid ||
              result_o.last_piece !== expected_pieces[0].last_piece ||
              result_o.table_overflow !== expected_pieces[0].table_overflow) begin
            $display("%0t: expected %h..%h v%b l%b o%b, got %h..%h v%b l%b o%b",
                     $time, expected_pieces[0].piece_low, expected_pieces[0].piece_high,
                     expected_pieces[0].piece_valid, expected_pieces[0].last_piece,
                     expected_pieces[0].table_overflow, result_o.piece_low,
                     result_o.piece_high, result_o.piece_valid, result_o.last_piece,
                     result_o.table_overflow);
            mismatches++;
          end
          void'(expected_pieces.pop_front());
        end
      end
      pop <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Watchdog against a block that stops producing or stops accepting.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void queue_cmd(op_e act, logic [31:0] lo, logic [31:0] hi);
    rss_item_t it;
    it.action     = act;
    it.range_low  = lo;
    it.range_high = hi;
    cmd_backlog.push_back(it);
    queued_count++;
  endfunction

  // Moves an address forward by a random step, saturating at the top of the
  // address space so that the edges get hit as well.
  function automatic logic [31:0] advance(logic [31:0] cur, int unsigned min_step,
                                          int unsigned max_step);
    logic [32:0] sum;
    sum = {1'b0, cur} + 33'($urandom_range(max_step, min_step));
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // One well-formed session: clear, fill the table with ascending disjoint
  // exclusions, then stream ascending keep ranges over the same window,
  // sometimes rewinding and streaming them again.
  task automatic queue_session(int unsigned n_bars, int unsigned n_keeps);
    logic [31:0] origin;
    logic [31:0] cur;
    logic [31:0] lo;
    logic [31:0] hi;
    int unsigned span;
    int unsigned passes;
    case ($urandom_range(3, 0))
      0: span = 2;
      1: span = 40;
      2: span = 4000;
      default: span = 32'h0400_0000;
    endcase
    case ($urandom_range(9, 0))
      0, 1: origin = '0;
      2, 3, 4: origin = 32'hFFFF_FFFF - $urandom_range(2000, 0);
      default: origin = $urandom;
    endcase
    queue_cmd(OP_CLEAR, $urandom, $urandom);
    cur = origin;
    for (int unsigned i = 0; i < n_bars; i++) begin
      lo = advance(cur, (i == 0) ? 0 : 1, span);
      hi = advance(lo, 0, span);
      queue_cmd(OP_APPEND, lo, hi);
      cur = hi;
    end
    passes = ($urandom_range(3, 0) == 0) ? 2 : 1;
    for (int unsigned p = 0; p < passes; p++) begin
      if (p != 0) queue_cmd(OP_REWIND, $urandom, $urandom);
      cur = origin;
      for (int unsigned j = 0; j < n_keeps; j++) begin
        lo = advance(cur, (j == 0) ? 0 : 1, span * 2);
        hi = advance(lo, 0, span * 3);
        if ($urandom_range(9, 0) == 0) queue_cmd(OP_FILTER, hi, lo);
        else queue_cmd(OP_FILTER, lo, hi);
        cur = hi;
      end
    end
  endtask

  // Random part of one phase: mostly sessions, the rest single transactions
  // with arbitrary action and addresses.
  task automatic queue_random_phase(int unsigned budget, bit with_overflow);
    int unsigned stop_at;
    int unsigned n_bars;
    stop_at = queued_count + budget;
    if (with_overflow) queue_session(EXCL_DEPTH + 2, 4);
    while (queued_count < stop_at) begin
      if ($urandom_range(99, 0) < 15) begin
        queue_cmd(op_e'($urandom_range(3, 0)), $urandom, $urandom);
      end else begin
        case ($urandom_range(9, 0))
          0: n_bars = $urandom_range(EXCL_DEPTH + 2, EXCL_DEPTH - 2);
          1, 2, 3: n_bars = $urandom_range(20, 7);
          default: n_bars = $urandom_range(6, 0);
        endcase
        queue_session(n_bars, $urandom_range(8, 1));
      end
    end
  endtask

  task automatic wait_all_accepted();
    while (accepted_count != queued_count) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Slow receiver, result queue backs up into the engine. The phase opens
    // with the directed cases.
    send_idle_pct = 23;
    recv_idle_pct = 75;
    // Empty table: a keep range survives whole, the full space included,
    // and an inverted one yields a single not-valid piece.
    queue_cmd(OP_FILTER, 32'h0, 32'h0);
    queue_cmd(OP_FILTER, 32'h5, 32'h4);
    queue_cmd(OP_FILTER, 32'h0, 32'hFFFF_FFFF);
    queue_cmd(OP_APPEND, 32'h10, 32'h1F);
    queue_cmd(OP_APPEND, 32'h30, 32'h3F);
    queue_cmd(OP_APPEND, 32'h50, 32'h5F);
    queue_cmd(OP_APPEND, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    // Keep range wholly below the first exclusion.
    queue_cmd(OP_FILTER, 32'h0, 32'hF);
    // Exact match with an exclusion: nothing survives.
    queue_cmd(OP_FILTER, 32'h10, 32'h1F);
    // Spans a gap and ends inside an exclusion: two pieces.
    queue_cmd(OP_FILTER, 32'h20, 32'h58);
    // Runs to the top, clipped by the last exclusion.
    queue_cmd(OP_FILTER, 32'h60, 32'hFFFF_FFFF);
    // After a rewind the whole space gives every gap.
    queue_cmd(OP_REWIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(OP_FILTER, 32'h0, 32'hFFFF_FFFF);
    queue_cmd(OP_FILTER, 32'hFFFF_FFFF, 32'h0);
    // Unsorted and inverted exclusions are stored as given.
    queue_cmd(OP_CLEAR, 32'h0, 32'h0);
    queue_cmd(OP_APPEND, 32'h100, 32'h1FF);
    queue_cmd(OP_APPEND, 32'h50, 32'h60);
    queue_cmd(OP_APPEND, 32'h300, 32'h2FF);
    queue_cmd(OP_FILTER, 32'h0, 32'h400);
    queue_cmd(OP_REWIND, 32'h0, 32'h0);
    queue_cmd(OP_FILTER, 32'h0, 32'h400);
    queue_random_phase(55, 1'b0);
    wait_all_accepted();

    // Slow sender, the engine mostly waits for work. This phase also fills
    // the table past its depth to raise the sticky overflow flag.
    send_idle_pct = 75;
    recv_idle_pct = 23;
    queue_random_phase(55, 1'b1);
    wait_all_accepted();

    // Both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_phase(55, 1'b0);
    wait_all_accepted();

    while (expected_pieces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
